// ===== rtl/core/rtg_pkg.sv =====
`timescale 1ns / 1ps

package rtg_pkg;

    localparam int PIX_W     = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [MODE_W-1:0] MODE_LUMA   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVG    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DESAT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_THRESH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;

    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_LUMA;
    localparam logic [PIX_W-1:0]  LEVEL_RESET = 8'd128;

    localparam logic [PIX_W-1:0] GRAY_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] GRAY_BLACK = 8'd0;

    // Luma weights, 0.299 / 0.587 / 0.114 scaled by 2^16
    localparam int WEIGHT_W     = 16;
    localparam int WEIGHT_SHIFT = 16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 16'd19595;
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 16'd38470;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 16'd7471;

    // floor(x/3) == (x*683) >> 11 for x < 2048
    localparam int SUM_W      = PIX_W + 2;
    localparam int RECIP_W    = 10;
    localparam int RECIP_SH   = 11;
    localparam logic [RECIP_W-1:0] RECIP_3 = 10'd683;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PIX_W-1:0]  level;
    } t_cfg;

endpackage

// ===== rtl/core/rtg_calc.sv =====
`timescale 1ns / 1ps

module rtg_calc (
    input  rtg_pkg::t_cfg                 i_cfg,
    input  logic [rtg_pkg::PIX_W-1:0]     i_red,
    input  logic [rtg_pkg::PIX_W-1:0]     i_green,
    input  logic [rtg_pkg::PIX_W-1:0]     i_blue,
    output logic [rtg_pkg::PIX_W-1:0]     o_gray
);

    localparam int LUMA_W = rtg_pkg::PIX_W + rtg_pkg::WEIGHT_W + 2;
    localparam int PROD_W = rtg_pkg::SUM_W + rtg_pkg::RECIP_W;

    logic [LUMA_W-1:0]              luma_sum;
    logic [rtg_pkg::SUM_W-1:0]      ch_sum;
    logic [PROD_W-1:0]              avg_prod;
    logic [rtg_pkg::PIX_W-1:0]      avg;
    logic [rtg_pkg::PIX_W-1:0]      hi;
    logic [rtg_pkg::PIX_W-1:0]      lo;
    logic [rtg_pkg::PIX_W:0]        hl_sum;

    assign luma_sum = LUMA_W'(i_red)   * LUMA_W'(rtg_pkg::WEIGHT_RED)
                    + LUMA_W'(i_green) * LUMA_W'(rtg_pkg::WEIGHT_GREEN)
                    + LUMA_W'(i_blue)  * LUMA_W'(rtg_pkg::WEIGHT_BLUE);

    assign ch_sum   = rtg_pkg::SUM_W'(i_red) + rtg_pkg::SUM_W'(i_green)
                    + rtg_pkg::SUM_W'(i_blue);
    assign avg_prod = PROD_W'(ch_sum) * PROD_W'(rtg_pkg::RECIP_3);
    assign avg      = avg_prod[rtg_pkg::RECIP_SH +: rtg_pkg::PIX_W];

    always_comb begin
        hi = i_red;
        lo = i_red;
        if (i_green > hi) hi = i_green;
        if (i_blue > hi)  hi = i_blue;
        if (i_green < lo) lo = i_green;
        if (i_blue < lo)  lo = i_blue;
    end

    assign hl_sum = {1'b0, hi} + {1'b0, lo};

    always_comb begin
        case (i_cfg.mode)
            rtg_pkg::MODE_LUMA:   o_gray = luma_sum[rtg_pkg::WEIGHT_SHIFT +: rtg_pkg::PIX_W];
            rtg_pkg::MODE_AVG:    o_gray = avg;
            rtg_pkg::MODE_DESAT:  o_gray = hl_sum[rtg_pkg::PIX_W:1];
            rtg_pkg::MODE_THRESH: o_gray = (avg >= i_cfg.level) ? rtg_pkg::GRAY_WHITE
                                                                : rtg_pkg::GRAY_BLACK;
            default:              o_gray = rtg_pkg::GRAY_BLACK;
        endcase
    end

endmodule

// ===== rtl/core/rgb_to_gray_multimode_top.sv =====
`timescale 1ns / 1ps

// RGB to gray converter, four methods chosen by gray_mode (index 0): weighted
// luminance, average, desaturation (max+min)/2, and black/white threshold
// against threshold_level (index 1). One pixel per clock is accepted unless
// the input is stalled, and each gives one gray value on the output through an
// input register, then the conversion logic, then the output register. Both
// stages advance independently, so the input is stalled only while both hold
// data and the output is stalled. Registers are written through the cfg port,
// which is always ready; write them only while no pixel is in flight.

module rgb_to_gray_multimode_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rtg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rtg_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rtg_pkg::PIX_W-1:0]       i_red,
    input  logic [rtg_pkg::PIX_W-1:0]       i_green,
    input  logic [rtg_pkg::PIX_W-1:0]       i_blue,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rtg_pkg::PIX_W-1:0]       o_gray
);

    rtg_pkg::t_cfg                  r_cfg;
    logic                           r_s1_vld;
    logic [rtg_pkg::PIX_W-1:0]      r_red;
    logic [rtg_pkg::PIX_W-1:0]      r_green;
    logic [rtg_pkg::PIX_W-1:0]      r_blue;
    logic                           r_out_vld;
    logic [rtg_pkg::PIX_W-1:0]      r_gray;
    logic [rtg_pkg::PIX_W-1:0]      n_gray;
    logic                           out_move;
    logic                           s1_load;
    logic                           in_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= rtg_pkg::MODE_RESET;
            r_cfg.level <= rtg_pkg::LEVEL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rtg_pkg::REG_GRAY_MODE: r_cfg.mode  <= i_cfg_data[rtg_pkg::MODE_W-1:0];
                rtg_pkg::REG_THRESHOLD: r_cfg.level <= i_cfg_data[rtg_pkg::PIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_move   = !r_out_vld || !i_out_stall;
    assign s1_load    = !r_s1_vld || out_move;
    assign o_in_stall = !s1_load;
    assign in_acc     = i_in_valid && s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_load) r_s1_vld <= i_in_valid;
            if (out_move) r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
        if (out_move && r_s1_vld) r_gray <= n_gray;
    end

    rtg_calc u_calc (
        .i_cfg   (r_cfg),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_gray  (n_gray)
    );

    assign o_out_valid = r_out_vld;
    assign o_gray      = r_gray;

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_vld && r_out_vld && i_out_stall))
        else $error("input stalled with a free stage");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !out_move) |=> (r_s1_vld && $stable(r_red) && $stable(r_green)
                                     && $stable(r_blue)))
        else $error("stage 1 transaction lost while output stalled");

    a_out_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && out_move) |=> (r_out_vld && r_gray == $past(n_gray)))
        else $error("stage 1 transaction not moved to output");

    a_thresh_bw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_cfg.mode == rtg_pkg::MODE_THRESH)
            |-> (n_gray == rtg_pkg::GRAY_WHITE || n_gray == rtg_pkg::GRAY_BLACK))
        else $error("threshold mode gave a grey level");

endmodule
